/* src/spsm_pkg.sv */
// spsm_pkg: item types, keep mask codes and keep-to-byte decode for the
// stream packet size monitor
// no dependencies
package spsm_pkg;

  // recognized keep masks
  localparam logic [3:0] KeepNone   = 4'h0;
  localparam logic [3:0] KeepLo1    = 4'h1;
  localparam logic [3:0] KeepLo2    = 4'h3;
  localparam logic [3:0] KeepLo3    = 4'h7;
  localparam logic [3:0] KeepAll    = 4'hF;
  localparam logic [3:0] KeepHi3    = 4'hE;
  localparam logic [3:0] KeepHi2    = 4'hC;
  localparam logic [3:0] KeepHi1    = 4'h8;

  localparam int unsigned CountW = 32;
  localparam int unsigned BytesW = 3;

  typedef struct packed {
    logic       measure;
    logic       beat_valid;
    logic [3:0] beat_keep;
    logic       beat_last;
    logic       cycle_sink_ready;
    logic       beat_sink_ready;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] packet_bytes;
    logic              packet_bytes_valid;
    logic [BytesW-1:0] beat_bytes;
    logic              cycle_report_valid;
    logic [CountW-1:0] cycle_report;
    logic              beat_report_valid;
    logic [CountW-1:0] beat_report;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [BytesW-1:0] bytes;
  } keep_dec_t;

  // contiguous keep masks to byte count, hit low for anything else
  function automatic keep_dec_t keep_decode(input logic [3:0] keep);
    keep_dec_t r;
    r.hit   = 1'b1;
    r.bytes = '0;
    case (keep)
      KeepNone: r.bytes = 3'd0;
      KeepLo1:  r.bytes = 3'd1;
      KeepLo2:  r.bytes = 3'd2;
      KeepLo3:  r.bytes = 3'd3;
      KeepAll:  r.bytes = 3'd4;
      KeepHi3:  r.bytes = 3'd3;
      KeepHi2:  r.bytes = 3'd2;
      KeepHi1:  r.bytes = 3'd1;
      default:  r.hit   = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* src/spsm_counters.sv */
// spsm_counters: measurement state (cycle/beat totals, byte accumulator,
// packet size) and the result for the current item; uses spsm_pkg
module spsm_counters import spsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [CountW-1:0] cycle_q, cycle_d;
  logic [CountW-1:0] beat_q, beat_d;
  logic [CountW-1:0] acc_q, acc_d;
  logic [CountW-1:0] pkt_q, pkt_d;
  logic              pkt_valid_q, pkt_valid_d;
  logic [BytesW-1:0] last_bytes_q, last_bytes_d;
  logic              measure_q;

  logic              rising, falling, take_beat;
  logic [CountW-1:0] cycle_base, beat_base, acc_sum;
  keep_dec_t         dec;

  // edge detection on the measure level
  assign rising    = item_i.measure & ~measure_q;
  assign falling   = ~item_i.measure & measure_q;
  assign take_beat = item_i.measure & item_i.beat_valid;

  assign cycle_base = rising ? '0 : cycle_q;
  assign beat_base  = rising ? '0 : beat_q;
  assign dec        = keep_decode(item_i.beat_keep);

  // next state
  always_comb begin
    cycle_d      = cycle_base;
    beat_d       = beat_base;
    acc_d        = acc_q;
    pkt_d        = pkt_q;
    pkt_valid_d  = pkt_valid_q;
    last_bytes_d = last_bytes_q;
    acc_sum      = '0;
    if (item_i.measure) begin
      cycle_d = cycle_base + CountW'(1);
      if (take_beat) begin
        beat_d       = beat_base + CountW'(1);
        last_bytes_d = dec.hit ? dec.bytes : last_bytes_q;
        acc_sum      = acc_q + CountW'(last_bytes_d);
        if (item_i.beat_last) begin
          pkt_d       = acc_sum;
          acc_d       = '0;
          pkt_valid_d = 1'b1;
        end else begin
          acc_d       = acc_sum;
          pkt_valid_d = 1'b0;
        end
      end
    end
  end

  // result: registered values before the update plus the edge reports
  always_comb begin
    result_o.packet_bytes       = pkt_q;
    result_o.packet_bytes_valid = pkt_valid_q;
    result_o.beat_bytes         = last_bytes_q;
    result_o.cycle_report_valid = falling & item_i.cycle_sink_ready;
    result_o.cycle_report       = result_o.cycle_report_valid ? cycle_base : '0;
    result_o.beat_report_valid  = falling & item_i.beat_sink_ready;
    result_o.beat_report        = result_o.beat_report_valid ? beat_base : '0;
  end

  // state registers, advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q      <= '0;
      beat_q       <= '0;
      acc_q        <= '0;
      pkt_q        <= '0;
      pkt_valid_q  <= 1'b0;
      last_bytes_q <= '0;
      measure_q    <= 1'b0;
    end else if (step_i) begin
      cycle_q      <= cycle_d;
      beat_q       <= beat_d;
      acc_q        <= acc_d;
      pkt_q        <= pkt_d;
      pkt_valid_q  <= pkt_valid_d;
      last_bytes_q <= last_bytes_d;
      measure_q    <= item_i.measure;
    end
  end

endmodule

/* src/stream_packet_size_monitor.sv */
// stream_packet_size_monitor: top level, input handshake and result register
// depends on spsm_pkg and spsm_counters
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_item_i (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//
// each item gives one result, shown on the output in the cycle after it is accepted;
// one item per cycle is sustained while out_stall_i is low, set by the single result register
// the state update and result are one pass of adders and a keep decode
// reset clears all counters, the edge detector and the result valid
// in_stall_o is high only while a held result is being stalled downstream
module stream_packet_size_monitor import spsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      accept;
  out_item_t result;
  logic      out_valid_q;
  out_item_t out_item_q;

  // take a new item whenever the result register is free or draining
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  spsm_counters u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .item_i   (in_item_i),
    .result_o (result)
  );

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* test/tb_top.sv */
// tb_top: self-checking bench for stream_packet_size_monitor, one tick per item
// holds a mirror of the monitor state that predicts each result, plus random drivers
// depends on spsm_pkg and the stream_packet_size_monitor rtl
`timescale 1ns / 100ps

module tb_top import spsm_pkg::*; ();

  // mirror of the monitor counters, predicts one result per accepted tick
  class size_report_board;
    logic [CountW-1:0] cycle_total = '0;
    logic [CountW-1:0] beat_total  = '0;
    logic [CountW-1:0] byte_sum    = '0;
    logic [CountW-1:0] done_bytes  = '0;
    logic [BytesW-1:0] last_bytes  = '0;
    logic              done_valid  = 1'b0;
    logic              level_seen  = 1'b0;
    out_item_t         expected_reports[$];
    int unsigned       failures = 0;

    // advance the mirror by one tick and queue the predicted result
    function void note_tick(in_item_t it);
      out_item_t         r;
      logic [BytesW-1:0] nb;
      logic              hit;
      logic              rise;
      logic              fall;
      r    = '0;
      nb   = '0;
      hit  = 1'b1;
      rise = !level_seen && it.measure;
      fall = level_seen && !it.measure;
      // registered outputs show the state before this tick
      r.packet_bytes       = done_bytes;
      r.packet_bytes_valid = done_valid;
      r.beat_bytes         = last_bytes;
      if (rise) begin
        cycle_total = '0;
        beat_total  = '0;
      end
      // falling edge offers totals, dropped if the sink is not ready
      if (fall && it.cycle_sink_ready) begin
        r.cycle_report_valid = 1'b1;
        r.cycle_report       = cycle_total;
      end
      if (fall && it.beat_sink_ready) begin
        r.beat_report_valid = 1'b1;
        r.beat_report       = beat_total;
      end
      if (it.measure) begin
        cycle_total = cycle_total + CountW'(1);
        if (it.beat_valid) begin
          beat_total = beat_total + CountW'(1);
          case (it.beat_keep)
            KeepNone: nb = 3'd0;
            KeepLo1:  nb = 3'd1;
            KeepLo2:  nb = 3'd2;
            KeepLo3:  nb = 3'd3;
            KeepAll:  nb = 3'd4;
            KeepHi3:  nb = 3'd3;
            KeepHi2:  nb = 3'd2;
            KeepHi1:  nb = 3'd1;
            default:  hit = 1'b0;
          endcase
          // unrecognized keep reuses the previous byte count
          if (hit) last_bytes = nb;
          byte_sum = byte_sum + CountW'(last_bytes);
          if (it.beat_last) begin
            done_bytes = byte_sum;
            byte_sum   = '0;
            done_valid = 1'b1;
          end else begin
            done_valid = 1'b0;
          end
        end
      end
      level_seen = it.measure;
      expected_reports.push_back(r);
    endfunction

    function void check_field(string name, logic [CountW-1:0] e, logic [CountW-1:0] a);
      if (e !== a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        failures++;
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_report(out_item_t got);
      out_item_t e;
      if (expected_reports.size() == 0) begin
        $error("result with no prediction pending: %h", got);
        failures++;
        return;
      end
      e = expected_reports.pop_front();
      check_field("packet_bytes", e.packet_bytes, got.packet_bytes);
      check_field("packet_bytes_valid", CountW'(e.packet_bytes_valid),
                  CountW'(got.packet_bytes_valid));
      check_field("beat_bytes", CountW'(e.beat_bytes), CountW'(got.beat_bytes));
      check_field("cycle_report_valid", CountW'(e.cycle_report_valid),
                  CountW'(got.cycle_report_valid));
      check_field("cycle_report", e.cycle_report, got.cycle_report);
      check_field("beat_report_valid", CountW'(e.beat_report_valid),
                  CountW'(got.beat_report_valid));
      check_field("beat_report", e.beat_report, got.beat_report);
    endfunction
  endclass

  localparam int unsigned CycleLimit  = 40000;
  localparam int unsigned RandomTicks = 600;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  size_report_board board = new;
  int unsigned      ticks_sent = 0;
  int unsigned      elapsed_clks = 0;
  logic [3:0]       listed_keeps[8] = '{KeepNone, KeepLo1, KeepLo2, KeepLo3,
                                        KeepAll, KeepHi3, KeepHi2, KeepHi1};

  stream_packet_size_monitor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk_i);
      elapsed_clks++;
      if (elapsed_clks > CycleLimit) begin
        $display("FAIL stream_packet_size_monitor");
        $finish;
      end
    end
  end

  // receiver stall: random, with a quiet stretch and two long hold-offs
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if ((rx_cycle >= 150 && rx_cycle < 250) || (rx_cycle >= 1000 && rx_cycle < 1060))
        out_stall_i <= 1'b1;
      else if (rx_cycle >= 500 && rx_cycle < 800)
        out_stall_i <= 1'b0;
      else
        out_stall_i <= ($urandom_range(0, 99) < 25);
    end
  end

  // result checker
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check_report(out_item_o);
    end
  end

  function automatic in_item_t mk_tick(logic m, logic v, logic [3:0] k, logic l,
                                       logic cr, logic br);
    in_item_t it;
    it.measure          = m;
    it.beat_valid       = v;
    it.beat_keep        = k;
    it.beat_last        = l;
    it.cycle_sink_ready = cr;
    it.beat_sink_ready  = br;
    return it;
  endfunction

  // random tick; mostly recognized keeps, beats offered at the given percentage
  function automatic in_item_t rand_tick(logic m, int unsigned beat_pct);
    logic [3:0] k;
    if ($urandom_range(0, 99) < 80) k = listed_keeps[3'($urandom_range(0, 7))];
    else k = 4'($urandom_range(0, 15));
    return mk_tick(m, $urandom_range(0, 99) < beat_pct, k, $urandom_range(0, 99) < 25,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // offer one item, entered and left at a falling edge
  task automatic push_tick(in_item_t it);
    int unsigned gap;
    gap = 0;
    if ((ticks_sent < 220 || ticks_sent >= 360) && $urandom_range(0, 99) < 25)
      gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    board.note_tick(it);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // stimulus and end of run
  initial begin
    int unsigned run_len;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: measure high on the first tick counts as a rising edge
    push_tick(mk_tick(1'b1, 1'b1, KeepAll, 1'b0, 1'b0, 1'b0));
    // unrecognized keep right after a full beat keeps the old count
    push_tick(mk_tick(1'b1, 1'b1, 4'h5, 1'b0, 1'b0, 1'b0));
    push_tick(mk_tick(1'b1, 1'b1, KeepNone, 1'b0, 1'b0, 1'b0));
    push_tick(mk_tick(1'b1, 1'b1, KeepLo1, 1'b0, 1'b0, 1'b0));
    push_tick(mk_tick(1'b1, 1'b1, KeepLo2, 1'b0, 1'b0, 1'b0));
    push_tick(mk_tick(1'b1, 1'b1, KeepLo3, 1'b0, 1'b0, 1'b0));
    push_tick(mk_tick(1'b1, 1'b1, KeepHi3, 1'b0, 1'b0, 1'b0));
    push_tick(mk_tick(1'b1, 1'b1, KeepHi2, 1'b0, 1'b0, 1'b0));
    push_tick(mk_tick(1'b1, 1'b1, KeepHi1, 1'b1, 1'b0, 1'b0));
    push_tick(mk_tick(1'b1, 1'b0, KeepAll, 1'b1, 1'b0, 1'b0));
    // falling edge with both sinks ready
    push_tick(mk_tick(1'b0, 1'b0, KeepNone, 1'b0, 1'b1, 1'b1));
    // beat while idle is ignored
    push_tick(mk_tick(1'b0, 1'b1, KeepAll, 1'b1, 1'b1, 1'b1));
    push_tick(mk_tick(1'b1, 1'b1, 4'h9, 1'b1, 1'b1, 1'b1));
    push_tick(mk_tick(1'b0, 1'b0, KeepNone, 1'b0, 1'b1, 1'b0));
    push_tick(mk_tick(1'b1, 1'b1, 4'h2, 1'b0, 1'b0, 1'b1));
    push_tick(mk_tick(1'b0, 1'b0, KeepNone, 1'b0, 1'b0, 1'b1));
    push_tick(mk_tick(1'b1, 1'b1, 4'h4, 1'b0, 1'b1, 1'b1));
    push_tick(mk_tick(1'b1, 1'b1, 4'h6, 1'b0, 1'b1, 1'b1));
    push_tick(mk_tick(1'b1, 1'b1, 4'hA, 1'b0, 1'b1, 1'b1));
    push_tick(mk_tick(1'b1, 1'b1, 4'hB, 1'b0, 1'b1, 1'b1));
    push_tick(mk_tick(1'b1, 1'b1, 4'hD, 1'b1, 1'b1, 1'b1));
    // falling edge with neither sink ready drops both totals
    push_tick(mk_tick(1'b0, 1'b0, KeepNone, 1'b0, 1'b0, 1'b0));
    push_tick(mk_tick(1'b0, 1'b1, 4'hF, 1'b1, 1'b1, 1'b1));
    push_tick(mk_tick(1'b1, 1'b1, KeepAll, 1'b1, 1'b1, 1'b1));
    push_tick(mk_tick(1'b0, 1'b0, KeepNone, 1'b0, 1'b1, 1'b1));

    // random measurement windows, with some fully random noise
    while (ticks_sent < RandomTicks) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          push_tick(rand_tick(1'($urandom_range(0, 1)), $urandom_range(0, 100)));
      end else begin
        repeat ($urandom_range(1, 5)) push_tick(rand_tick(1'b0, 50));
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        repeat (run_len) push_tick(rand_tick(1'b1, 75));
      end
    end
    in_valid_i <= 1'b0;

    // drain
    while (board.expected_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.failures == 0 && board.expected_reports.size() == 0) begin
      $display("PASS stream_packet_size_monitor");
    end else begin
      $display("FAIL stream_packet_size_monitor");
    end
    $finish;
  end

endmodule

/* stream_packet_size_monitor.f */
src/spsm_pkg.sv
src/spsm_counters.sv
src/stream_packet_size_monitor.sv
test/tb_top.sv
